// ===== design/mrlb_pkg.sv =====
// ----------------------------------------------------------------------------
// mrlb_pkg
// Shared types, codes and ring helpers for the message ring log buffer.
// ----------------------------------------------------------------------------
package mrlb_pkg;

	localparam int BUF_SIZE = 4096;
	localparam int ADDR_W   = $clog2(BUF_SIZE);
	localparam int CNT_W    = ADDR_W + 1;

	localparam logic [1:0] ACT_OPEN   = 2'd0;
	localparam logic [1:0] ACT_APPEND = 2'd1;
	localparam logic [1:0] ACT_REWIND = 2'd2;
	localparam logic [1:0] ACT_READ   = 2'd3;

	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_TOO_LONG = 2'd1;
	localparam logic [1:0] ST_EMPTY    = 2'd2;

	localparam logic [7:0] NUL_BYTE = 8'd0;
	localparam logic [7:0] NEWLINE  = 8'd10;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] data_byte;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [7:0]  out_byte;
		logic        dump_last;
		logic [12:0] message_count;
		logic [12:0] free_bytes;
	} res_t;

	function automatic logic [ADDR_W-1:0] ring_next(input logic [ADDR_W-1:0] p);
		logic [ADDR_W-1:0] r;
		if (p == ADDR_W'(BUF_SIZE - 1)) begin
			r = '0;
		end else begin
			r = p + ADDR_W'(1);
		end
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] free_count(
		input logic [CNT_W-1:0]  held,
		input logic [ADDR_W-1:0] os,
		input logic [ADDR_W-1:0] wt
	);
		logic [CNT_W-1:0] r;
		if (held == '0) begin
			r = CNT_W'(BUF_SIZE);
		end else if (os <= wt) begin
			r = CNT_W'(BUF_SIZE - 1) - {1'b0, wt} + {1'b0, os};
		end else begin
			r = {1'b0, os} - {1'b0, wt} - CNT_W'(1);
		end
		return r;
	endfunction

endpackage

// ===== design/message_ring_log_buffer.sv =====
// ----------------------------------------------------------------------------
// message_ring_log_buffer
// Byte ring of zero-terminated log messages with oldest-message eviction.
// ----------------------------------------------------------------------------
// cmd channel: cmd_valid / cmd_stall carry one item (action, data_byte).
// res channel: res_valid / res_stall return exactly one item per command:
// status, dump byte, dump_last, message count and free byte count.
// Items are handled one at a time by a sequencer around a single-port
// byte memory with registered read data.
// Path from accept to res_valid: rewind, ignored or rejected append and
// a read with no dump running go straight to S_OUT; a dump read passes
// S_RD, and open and append pass S_CHK and S_TERM. The next command is
// taken in the cycle after the result is loaded. When the ring is full,
// eviction adds an S_EV_RD / S_EV_CHK pair per evicted byte and one for
// its terminator, since every byte is read, checked and zeroed.
// Reset starts a clearing pass that zeroes all 4096 bytes of the store;
// cmd_stall stays high during that pass.
// The result register frees the sequencer: a new command is taken while
// an earlier result still waits; a stalled receiver holds the result
// and the sequencer waits to load the next one.
// ----------------------------------------------------------------------------
module message_ring_log_buffer (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  mrlb_pkg::cmd_t   cmd,
	output logic             res_valid,
	input  logic             res_stall,
	output mrlb_pkg::res_t   res
);

	typedef enum logic [2:0] {
		S_CLR, S_IDLE, S_CHK, S_EV_RD, S_EV_CHK, S_TERM, S_RD, S_OUT
	} state_t;

	state_t                          state_q;
	logic [mrlb_pkg::ADDR_W-1:0]     clr_q;
	logic [mrlb_pkg::ADDR_W-1:0]     os_q;
	logic [mrlb_pkg::ADDR_W-1:0]     wt_q;
	logic [mrlb_pkg::CNT_W-1:0]      held_q;
	logic [mrlb_pkg::ADDR_W-1:0]     rc_q;
	logic                            done_q;
	logic [mrlb_pkg::ADDR_W-1:0]     p_q;
	logic [mrlb_pkg::CNT_W-1:0]      k_q;
	logic [1:0]                      status_q;
	logic [7:0]                      obyte_q;
	logic                            last_q;
	logic                            res_valid_q;
	mrlb_pkg::res_t                  res_q;

	logic                            mem_en;
	logic                            mem_we;
	logic [mrlb_pkg::ADDR_W-1:0]     mem_addr;
	logic [7:0]                      mem_wdata;
	logic [7:0]                      mem_rdata;

	logic [mrlb_pkg::CNT_W-1:0]      free_w;
	logic                            app_live;
	logic                            app_full;
	logic                            scan_end;
	logic                            res_load;

	assign free_w   = mrlb_pkg::free_count(held_q, os_q, wt_q);
	assign app_live = (held_q != '0) && (cmd.data_byte != mrlb_pkg::NUL_BYTE);
	assign app_full = (held_q == mrlb_pkg::CNT_W'(1)) &&
	                  (free_w <= mrlb_pkg::CNT_W'(1));
	assign scan_end = (k_q == mrlb_pkg::CNT_W'(mrlb_pkg::BUF_SIZE));
	assign res_load = (state_q == S_OUT) && (!res_valid_q || !res_stall);

	mrlb_ram u_ram (
		.clk   (clk),
		.en    (mem_en),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	always_comb begin
		mem_en    = 1'b0;
		mem_we    = 1'b0;
		mem_addr  = wt_q;
		mem_wdata = mrlb_pkg::NUL_BYTE;
		case (state_q)
			S_CLR: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = clr_q;
			end
			S_IDLE: begin
				if (cmd_valid && cmd.action == mrlb_pkg::ACT_APPEND &&
				    app_live && !app_full) begin
					mem_en    = 1'b1;
					mem_we    = 1'b1;
					mem_addr  = wt_q;
					mem_wdata = cmd.data_byte;
				end else if (cmd_valid && cmd.action == mrlb_pkg::ACT_READ && !done_q) begin
					mem_en   = 1'b1;
					mem_addr = rc_q;
				end
			end
			S_EV_RD: begin
				mem_en   = !scan_end;
				mem_addr = p_q;
			end
			S_EV_CHK: begin
				mem_en   = (mem_rdata != mrlb_pkg::NUL_BYTE);
				mem_we   = 1'b1;
				mem_addr = p_q;
			end
			S_TERM: begin
				mem_en   = 1'b1;
				mem_we   = 1'b1;
				mem_addr = wt_q;
			end
			default: begin
				mem_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLR;
			clr_q       <= '0;
			os_q        <= '0;
			wt_q        <= mrlb_pkg::ADDR_W'(mrlb_pkg::BUF_SIZE - 1);
			held_q      <= '0;
			rc_q        <= '0;
			done_q      <= 1'b1;
			p_q         <= '0;
			k_q         <= '0;
			status_q    <= mrlb_pkg::ST_OK;
			obyte_q     <= '0;
			last_q      <= 1'b0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else begin
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !res_stall) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + mrlb_pkg::ADDR_W'(1);
					if (clr_q == mrlb_pkg::ADDR_W'(mrlb_pkg::BUF_SIZE - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						status_q <= mrlb_pkg::ST_OK;
						obyte_q  <= '0;
						last_q   <= 1'b0;
						case (cmd.action)
							mrlb_pkg::ACT_OPEN: begin
								wt_q    <= mrlb_pkg::ring_next(wt_q);
								held_q  <= held_q + mrlb_pkg::CNT_W'(1);
								state_q <= S_CHK;
							end
							mrlb_pkg::ACT_APPEND: begin
								if (app_live && app_full) begin
									status_q <= mrlb_pkg::ST_TOO_LONG;
									state_q  <= S_OUT;
								end else if (app_live) begin
									wt_q    <= mrlb_pkg::ring_next(wt_q);
									state_q <= S_CHK;
								end else begin
									state_q <= S_OUT;
								end
							end
							mrlb_pkg::ACT_REWIND: begin
								rc_q    <= os_q;
								done_q  <= (held_q == '0);
								state_q <= S_OUT;
							end
							default: begin
								if (done_q) begin
									status_q <= mrlb_pkg::ST_EMPTY;
									state_q  <= S_OUT;
								end else begin
									state_q <= S_RD;
								end
							end
						endcase
					end
				end
				S_CHK: begin
					if (free_w == '0) begin
						p_q     <= os_q;
						k_q     <= '0;
						state_q <= S_EV_RD;
					end else begin
						state_q <= S_TERM;
					end
				end
				S_EV_RD: begin
					if (scan_end) begin
						os_q <= mrlb_pkg::ring_next(p_q);
						if (held_q != '0) begin
							held_q <= held_q - mrlb_pkg::CNT_W'(1);
						end
						state_q <= S_TERM;
					end else begin
						state_q <= S_EV_CHK;
					end
				end
				S_EV_CHK: begin
					if (mem_rdata == mrlb_pkg::NUL_BYTE) begin
						os_q <= mrlb_pkg::ring_next(p_q);
						if (held_q != '0) begin
							held_q <= held_q - mrlb_pkg::CNT_W'(1);
						end
						state_q <= S_TERM;
					end else begin
						p_q     <= mrlb_pkg::ring_next(p_q);
						k_q     <= k_q + mrlb_pkg::CNT_W'(1);
						state_q <= S_EV_RD;
					end
				end
				S_TERM: begin
					state_q <= S_OUT;
				end
				S_RD: begin
					if (mem_rdata != mrlb_pkg::NUL_BYTE) begin
						obyte_q <= mem_rdata;
						rc_q    <= mrlb_pkg::ring_next(rc_q);
					end else begin
						obyte_q <= mrlb_pkg::NEWLINE;
						if (rc_q == wt_q) begin
							last_q <= 1'b1;
							done_q <= 1'b1;
						end else begin
							rc_q <= mrlb_pkg::ring_next(rc_q);
						end
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (res_load) begin
						res_q.status        <= status_q;
						res_q.out_byte      <= obyte_q;
						res_q.dump_last     <= last_q;
						res_q.message_count <= held_q;
						res_q.free_bytes    <= free_w;
						state_q             <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign cmd_stall = (state_q != S_IDLE);
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== design/mrlb_ram.sv =====
// ----------------------------------------------------------------------------
// mrlb_ram
// Single-port byte store of the ring, registered read data.
// ----------------------------------------------------------------------------
module mrlb_ram (
	input  logic                          clk,
	input  logic                          en,
	input  logic                          we,
	input  logic [mrlb_pkg::ADDR_W-1:0]   addr,
	input  logic [7:0]                    wdata,
	output logic [7:0]                    rdata
);

	logic [7:0] mem [mrlb_pkg::BUF_SIZE];
	logic [7:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata_q <= mem[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule
